// ===== rtl/core/c8x_pkg.sv =====
`timescale 1ns / 1ps
package c8x_pkg;

  localparam logic [15:0] RESET_PC_DEFAULT = 16'h0000;
  localparam logic [15:0] BREAK_VECTOR_DEFAULT = 16'h0000;
  localparam int QueueDepth = 2;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
    OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
    OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
    OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
    OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
    OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
    OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
    OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
    OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
    OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
  } op_t;

  typedef enum logic [0:0] {
    CFG_RESET_PC = 1'b0,
    CFG_BREAK_VECTOR = 1'b1
  } cfg_idx_t;

  localparam int FlagC = 0;
  localparam int FlagZ = 1;
  localparam int FlagI = 2;
  localparam int FlagD = 3;
  localparam int FlagB = 4;
  localparam int FlagU = 5;
  localparam int FlagV = 6;
  localparam int FlagN = 7;

  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] P_RESET = 8'h24;
  localparam logic [7:0] STACK_PAGE = 8'h01;

  typedef struct packed {
    logic [5:0]  operation;
    logic [7:0]  operand;
    logic [15:0] eff_addr;
    logic        accumulator_mode;
    logic [1:0]  instr_length;
    logic        page_crossed;
    logic [7:0]  pull_first;
    logic [7:0]  pull_second;
    logic [7:0]  pull_third;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        last_write;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  flags_out;
    logic [15:0] pc_out;
    logic [1:0]  extra_cycles;
  } out_item_t;

  // classification made by the front end
  typedef struct packed {
    logic is_branch;
    logic page_extra;
  } op_class_t;

  typedef struct packed {
    in_item_t  item;
    op_class_t cls;
  } q_entry_t;

endpackage

// ===== rtl/core/c8x_front.sv =====
`timescale 1ns / 1ps
module c8x_front
  import c8x_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output q_entry_t q_data
);

  q_entry_t mem_r [QueueDepth];
  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  op_class_t cls;
  logic push, pop;

  always_comb begin
    cls = '0;
    case (op_t'(in_data.operation)) inside
      OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL, OP_BVC, OP_BVS: cls.is_branch = 1'b1;
      OP_ADC, OP_AND, OP_CMP, OP_EOR, OP_LDA, OP_LDX, OP_LDY, OP_ORA, OP_SBC:
        cls.page_extra = 1'b1;
      default: cls = '0;
    endcase
  end

  assign in_ready = (cnt_r != (PtrW+1)'(QueueDepth));
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{item: in_data, cls: cls};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PtrW'(QueueDepth - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PtrW'(QueueDepth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/c8x_back.sv =====
`timescale 1ns / 1ps
module c8x_back
  import c8x_pkg::*;
#(
  parameter logic [15:0] ResetPc = RESET_PC_DEFAULT,
  parameter logic [15:0] BreakVector = BREAK_VECTOR_DEFAULT
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [15:0] cfg_data,
  input  logic      q_valid,
  output logic      q_ready,
  input  q_entry_t  q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [15:0] brk_r;
  logic [7:0] a_r, x_r, y_r, s_r, p_r;
  logic [15:0] pc_r;

  // pending writes of the current instruction
  logic [1:0] wn_r, wk_r;
  logic [15:0] wa_r [3];
  logic [7:0]  wd_r [3];
  out_item_t   tpl_r;
  logic        busy_r;

  logic [7:0] a_n, x_n, y_n, s_n, p_n;
  logic [15:0] pc_n;
  logic [1:0] ex_n, wn_n;
  logic [15:0] wa_n [3];
  logic [7:0]  wd_n [3];
  in_item_t it;
  op_class_t cl;
  logic [8:0] sum;
  logic [7:0] v, r, m;
  logic [15:0] ret;
  logic take;
  logic fire, last_take;

  assign it = q_data.item;
  assign cl = q_data.cls;
  assign cfg_ready = 1'b1;

  always_comb begin
    a_n = a_r; x_n = x_r; y_n = y_r; s_n = s_r; p_n = p_r;
    pc_n = pc_r + 16'(it.instr_length);
    ex_n = 2'd0; wn_n = 2'd0; take = 1'b0;
    m = it.operand;
    sum = '0; r = '0;
    v = it.accumulator_mode ? a_r : m;
    ret = pc_r + 16'd2;
    for (int i = 0; i < 3; i++) begin
      wa_n[i] = '0;
      wd_n[i] = '0;
    end
    if (cl.page_extra) ex_n = {1'b0, it.page_crossed};
    case (op_t'(it.operation))
      OP_ADC, OP_SBC: begin
        r = (op_t'(it.operation) == OP_SBC) ? ~m : m;
        sum = {1'b0, a_r} + {1'b0, r} + {8'd0, p_r[FlagC]};
        p_n[FlagC] = sum[8];
        p_n[FlagV] = (a_r[7] ^ sum[7]) & (r[7] ^ sum[7]);
        a_n = sum[7:0];
        p_n[FlagZ] = (a_n == 8'd0); p_n[FlagN] = a_n[7];
      end
      OP_AND, OP_EOR, OP_ORA, OP_LDA: begin
        case (op_t'(it.operation))
          OP_AND: a_n = a_r & m;
          OP_EOR: a_n = a_r ^ m;
          OP_ORA: a_n = a_r | m;
          default: a_n = m;
        endcase
        p_n[FlagZ] = (a_n == 8'd0); p_n[FlagN] = a_n[7];
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        case (op_t'(it.operation))
          OP_ASL: begin r = {v[6:0], 1'b0}; p_n[FlagC] = v[7]; end
          OP_LSR: begin r = {1'b0, v[7:1]}; p_n[FlagC] = v[0]; end
          OP_ROL: begin r = {v[6:0], p_r[FlagC]}; p_n[FlagC] = v[7]; end
          default: begin r = {p_r[FlagC], v[7:1]}; p_n[FlagC] = v[0]; end
        endcase
        p_n[FlagZ] = (r == 8'd0); p_n[FlagN] = r[7];
        if (it.accumulator_mode) a_n = r;
        else begin wn_n = 2'd1; wa_n[0] = it.eff_addr; wd_n[0] = r; end
      end
      OP_BCC: take = !p_r[FlagC];
      OP_BCS: take = p_r[FlagC];
      OP_BEQ: take = p_r[FlagZ];
      OP_BMI: take = p_r[FlagN];
      OP_BNE: take = !p_r[FlagZ];
      OP_BPL: take = !p_r[FlagN];
      OP_BVC: take = !p_r[FlagV];
      OP_BVS: take = p_r[FlagV];
      OP_BIT: begin
        p_n[FlagV] = m[6]; p_n[FlagN] = m[7]; p_n[FlagZ] = ((a_r & m) == 8'd0);
      end
      OP_BRK: begin
        wn_n = 2'd3;
        wa_n[0] = {STACK_PAGE, s_r};        wd_n[0] = ret[15:8];
        wa_n[1] = {STACK_PAGE, s_r - 8'd1}; wd_n[1] = ret[7:0];
        wa_n[2] = {STACK_PAGE, s_r - 8'd2}; wd_n[2] = p_r | 8'h30;
        s_n = s_r - 8'd3;
        p_n[FlagI] = 1'b1;
        pc_n = brk_r;
      end
      OP_CLC: p_n[FlagC] = 1'b0;
      OP_CLD: p_n[FlagD] = 1'b0;
      OP_CLI: p_n[FlagI] = 1'b0;
      OP_CLV: p_n[FlagV] = 1'b0;
      OP_SEC: p_n[FlagC] = 1'b1;
      OP_SED: p_n[FlagD] = 1'b1;
      OP_SEI: p_n[FlagI] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        case (op_t'(it.operation))
          OP_CMP: v = a_r;
          OP_CPX: v = x_r;
          default: v = y_r;
        endcase
        r = v - m;
        p_n[FlagC] = (v >= m); p_n[FlagZ] = (r == 8'd0); p_n[FlagN] = r[7];
      end
      OP_DEC, OP_INC: begin
        r = (op_t'(it.operation) == OP_DEC) ? m - 8'd1 : m + 8'd1;
        p_n[FlagZ] = (r == 8'd0); p_n[FlagN] = r[7];
        wn_n = 2'd1; wa_n[0] = it.eff_addr; wd_n[0] = r;
      end
      OP_DEX, OP_INX, OP_LDX, OP_TAX, OP_TSX: begin
        case (op_t'(it.operation))
          OP_DEX: x_n = x_r - 8'd1;
          OP_INX: x_n = x_r + 8'd1;
          OP_LDX: x_n = m;
          OP_TAX: x_n = a_r;
          default: x_n = s_r;
        endcase
        p_n[FlagZ] = (x_n == 8'd0); p_n[FlagN] = x_n[7];
      end
      OP_DEY, OP_INY, OP_LDY, OP_TAY: begin
        case (op_t'(it.operation))
          OP_DEY: y_n = y_r - 8'd1;
          OP_INY: y_n = y_r + 8'd1;
          OP_LDY: y_n = m;
          default: y_n = a_r;
        endcase
        p_n[FlagZ] = (y_n == 8'd0); p_n[FlagN] = y_n[7];
      end
      OP_TXA, OP_TYA, OP_PLA: begin
        case (op_t'(it.operation))
          OP_TXA: a_n = x_r;
          OP_TYA: a_n = y_r;
          default: begin a_n = it.pull_first; s_n = s_r + 8'd1; end
        endcase
        p_n[FlagZ] = (a_n == 8'd0); p_n[FlagN] = a_n[7];
      end
      OP_JMP: pc_n = it.eff_addr;
      OP_JSR: begin
        wn_n = 2'd2;
        wa_n[0] = {STACK_PAGE, s_r};        wd_n[0] = ret[15:8];
        wa_n[1] = {STACK_PAGE, s_r - 8'd1}; wd_n[1] = ret[7:0];
        s_n = s_r - 8'd2;
        pc_n = it.eff_addr;
      end
      OP_PHA, OP_PHP: begin
        wn_n = 2'd1; wa_n[0] = {STACK_PAGE, s_r};
        wd_n[0] = (op_t'(it.operation) == OP_PHA) ? a_r : (p_r | 8'h30);
        s_n = s_r - 8'd1;
      end
      OP_PLP: begin
        s_n = s_r + 8'd1; p_n = (it.pull_first & 8'hEF) | 8'h20;
      end
      OP_RTI: begin
        s_n = s_r + 8'd3; p_n = (it.pull_first & 8'hEF) | 8'h20;
        pc_n = {it.pull_third, it.pull_second};
      end
      OP_RTS: begin
        s_n = s_r + 8'd2; pc_n = {it.pull_second, it.pull_first} + 16'd1;
      end
      OP_STA, OP_STX, OP_STY: begin
        wn_n = 2'd1; wa_n[0] = it.eff_addr;
        case (op_t'(it.operation))
          OP_STA: wd_n[0] = a_r;
          OP_STX: wd_n[0] = x_r;
          default: wd_n[0] = y_r;
        endcase
      end
      OP_TXS: s_n = x_r;
      default: ;
    endcase
    if (cl.is_branch && take) begin
      pc_n = it.eff_addr;
      ex_n = 2'd1 + {1'b0, it.page_crossed};
    end
  end

  // output register holds one result; refills when it empties or is taken
  logic ovalid_r;
  out_item_t odata_r;
  logic slot_free;
  out_item_t first_o, rep_o;
  assign slot_free = !ovalid_r || out_ready;
  assign q_ready   = slot_free && !busy_r;
  assign fire      = q_valid && q_ready;
  assign last_take = busy_r && slot_free && (wk_r + 2'd1 == wn_r);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    first_o = '{write_valid: (wn_n != 2'd0), write_addr: wa_n[0], write_data: wd_n[0],
                last_write: (wn_n <= 2'd1), acc_out: a_n, x_out: x_n, y_out: y_n,
                sp_out: s_n, flags_out: p_n, pc_out: pc_n, extra_cycles: ex_n};
    rep_o = tpl_r;
    rep_o.write_addr = wa_r[wk_r];
    rep_o.write_data = wd_r[wk_r];
    rep_o.last_write = last_take;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tpl_r <= first_o;
      for (int i = 0; i < 3; i++) begin
        wa_r[i] <= wa_n[i];
        wd_r[i] <= wd_n[i];
      end
      odata_r <= first_o;
    end else if (busy_r && slot_free) begin
      odata_r <= rep_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r <= BreakVector;
      a_r <= '0; x_r <= '0; y_r <= '0; s_r <= SP_RESET; p_r <= P_RESET;
      pc_r <= ResetPc;
      ovalid_r <= 1'b0; busy_r <= 1'b0; wn_r <= '0; wk_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RESET_PC: pc_r <= cfg_data;
          CFG_BREAK_VECTOR: brk_r <= cfg_data;
          default: ;
        endcase
      end
      if (fire) begin
        a_r <= a_n; x_r <= x_n; y_r <= y_n; s_r <= s_n; p_r <= p_n; pc_r <= pc_n;
        ovalid_r <= 1'b1;
        busy_r <= (wn_n > 2'd1);
        wn_r <= wn_n; wk_r <= 2'd1;
      end else if (busy_r && slot_free) begin
        ovalid_r <= 1'b1;
        wk_r <= wk_r + 2'd1;
        if (last_take) busy_r <= 1'b0;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/cpu8_instruction_execute.sv =====
`timescale 1ns / 1ps
// Execute stage for an 8-bit 6502-class core, binary arithmetic only. A two-entry
// queue after the decode/classify front lets the back end stall on its own.
// Each stack or memory write gives one output item (BRK three, JSR two), and no
// new instruction is taken before the last is loaded. Otherwise the next one is
// accepted in the cycle the current result is taken.
module cpu8_instruction_execute
  import c8x_pkg::*;
#(
  parameter logic [15:0] ResetPc = RESET_PC_DEFAULT,
  parameter logic [15:0] BreakVector = BREAK_VECTOR_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic     q_valid, q_ready;
  q_entry_t q_data;

  c8x_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  c8x_back #(.ResetPc(ResetPc), .BreakVector(BreakVector)) u_back (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_valid, .q_ready, .q_data, .out_valid, .out_ready, .out_data
  );

endmodule
